FILE: sv/alsi_pkg.sv
// ----------------------------------------------------------------------------
// alsi_pkg
// Shared widths, event and command codes, state codes, register map and
// register reset values of the arm lease safety interlock.
// ----------------------------------------------------------------------------
package alsi_pkg;

    // item field widths
    localparam int FUNC_W  = 3;
    localparam int CMD_W   = 3;
    localparam int ARG_W   = 16;
    localparam int NOW_W   = 32;
    localparam int STATE_W = 4;

    // register widths and config port
    localparam int HOLD_W     = 16;
    localparam int LINK_W     = 20;
    localparam int LEASE_W    = 20;
    localparam int PULSE_W    = 16;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_IDX_W  = 3;

    // default deadline width
    localparam int TIME_BITS_DEF = 32;

    // register reset values
    localparam logic              ROLE_RST     = 1'b0;
    localparam logic [HOLD_W-1:0]  ARM_HOLD_RST = 16'd500;
    localparam logic [LINK_W-1:0]  LINK_RST     = 20'd1000;
    localparam logic [LEASE_W-1:0] LEASE_RST    = 20'd5000;
    localparam logic [PULSE_W-1:0] MAX_PULSE_RST = 16'd1000;

    // register index in the map
    localparam logic [CFG_IDX_W-1:0] REG_ROLE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ARM_HOLD  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LINK_LOSS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ARM_LEASE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PULSE = 3'd4;

    // roles
    localparam logic ROLE_WAND     = 1'b0;
    localparam logic ROLE_RECEIVER = 1'b1;

    // event codes
    localparam logic [FUNC_W-1:0] FN_TICK        = 3'd0;
    localparam logic [FUNC_W-1:0] FN_BOOT_DONE   = 3'd1;
    localparam logic [FUNC_W-1:0] FN_SET_PAIRING = 3'd2;
    localparam logic [FUNC_W-1:0] FN_ARM_BUTTON  = 3'd3;
    localparam logic [FUNC_W-1:0] FN_LINK_LOST   = 3'd4;
    localparam logic [FUNC_W-1:0] FN_FAULT       = 3'd5;
    localparam logic [FUNC_W-1:0] FN_COMMAND     = 3'd6;
    localparam logic [FUNC_W-1:0] FN_TAKE_DISARM = 3'd7;

    // remote command codes
    localparam logic [CMD_W-1:0] CMD_DISARM      = 3'd0;
    localparam logic [CMD_W-1:0] CMD_HEARTBEAT   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_ARM_LEASE   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SET_AUX     = 3'd3;
    localparam logic [CMD_W-1:0] CMD_PULSE_ISO   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_PULSE_LOW   = 3'd5;

    // state codes
    localparam logic [STATE_W-1:0] ST_BOOT         = 4'd0;
    localparam logic [STATE_W-1:0] ST_UNPAIRED     = 4'd1;
    localparam logic [STATE_W-1:0] ST_PAIRING_AUTH = 4'd2;
    localparam logic [STATE_W-1:0] ST_DISARMED     = 4'd3;
    localparam logic [STATE_W-1:0] ST_ARM_PENDING  = 4'd4;
    localparam logic [STATE_W-1:0] ST_ARMED        = 4'd5;
    localparam logic [STATE_W-1:0] ST_CMD_PENDING  = 4'd6;
    localparam logic [STATE_W-1:0] ST_FAULT        = 4'd7;
    localparam logic [STATE_W-1:0] ST_UPDATE       = 4'd8;

    // disarm frames queued on button release
    localparam logic [1:0] DISARM_FRAMES = 2'd3;

endpackage

FILE: sv/alsi_evt_if.sv
// ----------------------------------------------------------------------------
// alsi_evt_if
// Event channel: valid/ready handshake carrying one event item.
// ----------------------------------------------------------------------------
interface alsi_evt_if
    import alsi_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic              flag;
    logic [CMD_W-1:0]  command;
    logic [ARG_W-1:0]  argument;
    logic [NOW_W-1:0]  now_ms;

    modport source (output valid, func, flag, command, argument, now_ms, input ready);
    modport sink   (input valid, func, flag, command, argument, now_ms, output ready);
endinterface

FILE: sv/alsi_res_if.sv
// ----------------------------------------------------------------------------
// alsi_res_if
// Result channel: valid/ready handshake carrying one result item.
// ----------------------------------------------------------------------------
interface alsi_res_if
    import alsi_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               accepted;
    logic [STATE_W-1:0] state_code;
    logic               aux_on;
    logic               isolated_on;
    logic               low_side_on;
    logic               outputs_safe;

    modport source (output valid, accepted, state_code, aux_on, isolated_on, low_side_on,
                    outputs_safe, input ready);
    modport sink   (input valid, accepted, state_code, aux_on, isolated_on, low_side_on,
                    outputs_safe, output ready);
endinterface

FILE: sv/arm_lease_safety_interlock_core.sv
// Path: an accepted event item passes the input register, then the state update /
// result register, which presents its result item; while the result channel stalls,
// the item waits in the input register.
// Throughput: one event item per cycle while results are taken; the state update
// path is one deadline add plus a wraparound compare on registered state.
// Reset: rst_n clears mode to boot, all flags, drives, deadlines and the
// disarm frame count, and loads the register defaults; no clearing pass.
// ----------------------------------------------------------------------------
// arm_lease_safety_interlock_core
// Arming interlock for a remote trigger in wand or receiver role, with lease,
// heartbeat and pulse deadlines that force a safe state on expiry.
// ----------------------------------------------------------------------------
module arm_lease_safety_interlock_core
    import alsi_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
)(
    input  logic                  clk,
    input  logic                  rst_n,
    alsi_evt_if.sink              evt,
    alsi_res_if.source            res,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int SUM_W = (TIME_BITS > NOW_W) ? TIME_BITS : NOW_W;

    typedef logic [TIME_BITS-1:0] time_t;

    // wraparound deadline test: reached when (now - dl) has its top bit clear
    function automatic logic reached(input time_t now_v, input time_t dl_v);
        time_t d;
        d = now_v - dl_v;
        return !d[TIME_BITS-1];
    endfunction

    // configuration registers
    logic               role_reg;
    logic [HOLD_W-1:0]  arm_hold_reg;
    logic [LINK_W-1:0]  link_loss_reg;
    logic [LEASE_W-1:0] arm_lease_reg;
    logic [PULSE_W-1:0] max_pulse_reg;

    logic                 cfg_wr;
    logic [CFG_IDX_W-1:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[CFG_ADDR_W-1:2];

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            role_reg      <= ROLE_RST;
            arm_hold_reg  <= ARM_HOLD_RST;
            link_loss_reg <= LINK_RST;
            arm_lease_reg <= LEASE_RST;
            max_pulse_reg <= MAX_PULSE_RST;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_ROLE:      role_reg      <= pwdata[0];
                REG_ARM_HOLD:  arm_hold_reg  <= pwdata[HOLD_W-1:0];
                REG_LINK_LOSS: link_loss_reg <= pwdata[LINK_W-1:0];
                REG_ARM_LEASE: arm_lease_reg <= pwdata[LEASE_W-1:0];
                REG_MAX_PULSE: max_pulse_reg <= pwdata[PULSE_W-1:0];
                default:       ;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        unique case (cfg_idx)
            REG_ROLE:      prdata = CFG_DATA_W'(role_reg);
            REG_ARM_HOLD:  prdata = CFG_DATA_W'(arm_hold_reg);
            REG_LINK_LOSS: prdata = CFG_DATA_W'(link_loss_reg);
            REG_ARM_LEASE: prdata = CFG_DATA_W'(arm_lease_reg);
            REG_MAX_PULSE: prdata = CFG_DATA_W'(max_pulse_reg);
            default:       prdata = '0;
        endcase
    end

    // input register stage
    logic              s1_valid_reg;
    logic [FUNC_W-1:0] s1_func_reg;
    logic              s1_flag_reg;
    logic [CMD_W-1:0]  s1_cmd_reg;
    logic [ARG_W-1:0]  s1_arg_reg;
    logic [NOW_W-1:0]  s1_now_reg;

    logic res_valid_reg;
    logic s1_adv;
    logic evt_take;

    assign s1_adv    = s1_valid_reg && (!res_valid_reg || res.ready);
    assign evt.ready = !s1_valid_reg || s1_adv;
    assign evt_take  = evt.valid && evt.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (evt_take)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (evt_take)
        begin
            s1_func_reg <= evt.func;
            s1_flag_reg <= evt.flag;
            s1_cmd_reg  <= evt.command;
            s1_arg_reg  <= evt.argument;
            s1_now_reg  <= evt.now_ms;
        end
    end

    // interlock state
    logic [STATE_W-1:0] mode_reg,  mode_next;
    logic               paired_reg, paired_next;
    logic               button_reg, button_next;
    logic               aux_reg,   aux_next;
    logic               iso_reg,   iso_next;
    logic               low_reg,   low_next;
    time_t              pulse_dl_reg, pulse_dl_next;
    time_t              lease_dl_reg, lease_dl_next;
    time_t              hb_dl_reg,    hb_dl_next;
    time_t              press_reg,    press_next;
    logic [1:0]         frames_reg,   frames_next;
    logic               acc_next;

    // deadline sums, reduced to the deadline width
    logic [SUM_W-1:0] now_w;
    time_t            now_t;
    time_t            hb_new;
    time_t            lease_new;
    time_t            pulse_new;
    time_t            arm_dl;

    assign now_w     = SUM_W'(s1_now_reg);
    assign now_t     = now_w[TIME_BITS-1:0];
    assign hb_new    = TIME_BITS'(now_w + SUM_W'(link_loss_reg));
    assign lease_new = TIME_BITS'(now_w + SUM_W'(arm_lease_reg));
    assign pulse_new = TIME_BITS'(now_w + SUM_W'(s1_arg_reg));
    assign arm_dl    = TIME_BITS'(SUM_W'(press_reg) + SUM_W'(arm_hold_reg));

    logic locked;
    logic armed_like;
    logic lease_hit;
    logic hb_hit;
    logic pulse_hit;
    logic arm_hit;

    assign locked = (mode_reg == ST_BOOT) || (mode_reg == ST_UNPAIRED) ||
                    (mode_reg == ST_PAIRING_AUTH) || (mode_reg == ST_FAULT) ||
                    (mode_reg == ST_UPDATE);
    assign armed_like = (mode_reg == ST_ARMED) || (mode_reg == ST_CMD_PENDING);
    assign lease_hit  = reached(now_t, lease_dl_reg);
    assign hb_hit     = reached(now_t, hb_dl_reg);
    assign pulse_hit  = reached(now_t, pulse_dl_reg);
    assign arm_hit    = reached(now_t, arm_dl);

    // event handling
    always_comb
    begin
        logic go_safe;
        logic drv_off;
        logic [STATE_W-1:0] safe_mode;

        mode_next     = mode_reg;
        paired_next   = paired_reg;
        button_next   = button_reg;
        aux_next      = aux_reg;
        iso_next      = iso_reg;
        low_next      = low_reg;
        pulse_dl_next = pulse_dl_reg;
        lease_dl_next = lease_dl_reg;
        hb_dl_next    = hb_dl_reg;
        press_next    = press_reg;
        frames_next   = frames_reg;
        acc_next      = 1'b0;
        go_safe       = 1'b0;
        drv_off       = 1'b0;
        safe_mode     = ST_DISARMED;

        unique case (s1_func_reg)
            FN_TICK:
            begin
                if (role_reg == ROLE_WAND)
                begin
                    if (mode_reg == ST_ARM_PENDING && button_reg && arm_hit)
                    begin
                        mode_next = ST_ARMED;
                    end
                end
                else if (armed_like && (lease_hit || hb_hit))
                begin
                    go_safe = 1'b1;
                end
                else if (mode_reg == ST_CMD_PENDING && (iso_reg || low_reg) && pulse_hit)
                begin
                    drv_off   = 1'b1;
                    mode_next = ST_ARMED;
                end
            end
            FN_BOOT_DONE:
            begin
                drv_off     = 1'b1;
                paired_next = s1_flag_reg;
                if (role_reg == ROLE_WAND && button_reg)
                begin
                    mode_next = ST_FAULT;
                end
                else
                begin
                    mode_next = s1_flag_reg ? ST_DISARMED : ST_UNPAIRED;
                end
            end
            FN_SET_PAIRING:
            begin
                go_safe     = 1'b1;
                safe_mode   = s1_flag_reg ? ST_DISARMED : ST_UNPAIRED;
                paired_next = s1_flag_reg;
            end
            FN_ARM_BUTTON:
            begin
                if (role_reg == ROLE_WAND)
                begin
                    button_next = s1_flag_reg;
                    if (!locked)
                    begin
                        if (!s1_flag_reg)
                        begin
                            go_safe     = 1'b1;
                            frames_next = DISARM_FRAMES;
                        end
                        else if (mode_reg == ST_DISARMED)
                        begin
                            press_next = now_t;
                            mode_next  = ST_ARM_PENDING;
                        end
                    end
                end
            end
            FN_LINK_LOST:
            begin
                go_safe   = 1'b1;
                safe_mode = paired_reg ? ST_DISARMED : ST_UNPAIRED;
            end
            FN_FAULT:
            begin
                go_safe   = 1'b1;
                safe_mode = ST_FAULT;
            end
            FN_COMMAND:
            begin
                if (role_reg == ROLE_RECEIVER && paired_reg && !locked)
                begin
                    priority if (s1_cmd_reg == CMD_DISARM)
                    begin
                        go_safe  = 1'b1;
                        acc_next = 1'b1;
                    end
                    else if (s1_cmd_reg == CMD_HEARTBEAT)
                    begin
                        hb_dl_next = hb_new;
                        acc_next   = 1'b1;
                    end
                    else if (s1_cmd_reg == CMD_ARM_LEASE)
                    begin
                        lease_dl_next = lease_new;
                        hb_dl_next    = hb_new;
                        mode_next     = ST_ARMED;
                        acc_next      = 1'b1;
                    end
                    else if (!armed_like || lease_hit)
                    begin
                        go_safe = 1'b1;
                    end
                    else
                    begin
                        hb_dl_next = hb_new;
                        if (s1_cmd_reg == CMD_SET_AUX)
                        begin
                            if (s1_arg_reg[ARG_W-1:1] == '0)
                            begin
                                drv_off   = 1'b1;
                                mode_next = s1_arg_reg[0] ? ST_CMD_PENDING : ST_ARMED;
                                acc_next  = 1'b1;
                            end
                        end
                        else if (s1_cmd_reg == CMD_PULSE_ISO || s1_cmd_reg == CMD_PULSE_LOW)
                        begin
                            if (s1_arg_reg != '0 && s1_arg_reg <= max_pulse_reg)
                            begin
                                drv_off   = 1'b1;
                                mode_next = ST_CMD_PENDING;
                                acc_next  = 1'b1;
                            end
                        end
                    end
                end
            end
            FN_TAKE_DISARM:
            begin
                if (role_reg == ROLE_WAND && frames_reg != 2'd0)
                begin
                    frames_next = frames_reg - 2'd1;
                    acc_next    = 1'b1;
                end
            end
        endcase

        // drives off, and on a safe drop also the lease, heartbeat and mode
        if (go_safe || drv_off)
        begin
            aux_next      = 1'b0;
            iso_next      = 1'b0;
            low_next      = 1'b0;
            pulse_dl_next = '0;
        end
        if (go_safe)
        begin
            lease_dl_next = '0;
            hb_dl_next    = '0;
            mode_next     = safe_mode;
        end

        // new drive settings from an accepted aux or pulse command
        if (s1_func_reg == FN_COMMAND && acc_next && drv_off)
        begin
            if (s1_cmd_reg == CMD_SET_AUX)
            begin
                aux_next = s1_arg_reg[0];
            end
            else
            begin
                iso_next      = (s1_cmd_reg == CMD_PULSE_ISO);
                low_next      = (s1_cmd_reg == CMD_PULSE_LOW);
                pulse_dl_next = pulse_new;
            end
        end
    end

    // state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= ST_BOOT;
            paired_reg   <= 1'b0;
            button_reg   <= 1'b0;
            aux_reg      <= 1'b0;
            iso_reg      <= 1'b0;
            low_reg      <= 1'b0;
            pulse_dl_reg <= '0;
            lease_dl_reg <= '0;
            hb_dl_reg    <= '0;
            press_reg    <= '0;
            frames_reg   <= 2'd0;
        end
        else if (s1_adv)
        begin
            mode_reg     <= mode_next;
            paired_reg   <= paired_next;
            button_reg   <= button_next;
            aux_reg      <= aux_next;
            iso_reg      <= iso_next;
            low_reg      <= low_next;
            pulse_dl_reg <= pulse_dl_next;
            lease_dl_reg <= lease_dl_next;
            hb_dl_reg    <= hb_dl_next;
            press_reg    <= press_next;
            frames_reg   <= frames_next;
        end
    end

    // result register
    logic               res_acc_reg;
    logic [STATE_W-1:0] res_state_reg;
    logic               res_aux_reg;
    logic               res_iso_reg;
    logic               res_low_reg;
    logic               res_safe_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            res_acc_reg   <= acc_next;
            res_state_reg <= mode_next;
            res_aux_reg   <= aux_next;
            res_iso_reg   <= iso_next;
            res_low_reg   <= low_next;
            res_safe_reg  <= !aux_next && !iso_next && !low_next;
        end
    end

    assign res.valid        = res_valid_reg;
    assign res.accepted     = res_acc_reg;
    assign res.state_code   = res_state_reg;
    assign res.aux_on       = res_aux_reg;
    assign res.isolated_on  = res_iso_reg;
    assign res.low_side_on  = res_low_reg;
    assign res.outputs_safe = res_safe_reg;

    // at most one output drive is ever on
    a_one_drive: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({aux_reg, iso_reg, low_reg}))
        else $error("more than one output drive active");

    // a stalled item in the input register is not dropped
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_adv) |=> s1_valid_reg)
        else $error("input register item lost under stall");

    // a new result only follows a processed item
    a_res_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(s1_valid_reg))
        else $error("result appeared without an item");

    // pairing-auth and update states are never entered
    a_no_unused: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg != ST_PAIRING_AUTH && mode_reg != ST_UPDATE) |=>
        (mode_reg != ST_PAIRING_AUTH && mode_reg != ST_UPDATE))
        else $error("unused state entered");

endmodule

FILE: dv/arm_lease_safety_interlock_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arm_lease_safety_interlock_core_tb
// Drives event items into the interlock in wand and receiver role, predicts
// the status item of every accepted event with a behavioral copy of the state
// machine and its deadlines, and checks each status item as it leaves the
// block. Registers are rewritten between phases, extremes included, and both
// channels idle at random.
// ----------------------------------------------------------------------------
module arm_lease_safety_interlock_core_tb;
    import alsi_pkg::*;

    // command codes the package leaves unnamed
    localparam logic [CMD_W-1:0] CMD_FEEDBACK = 3'd6;
    localparam logic [CMD_W-1:0] CMD_RESERVED = 3'd7;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned PHASE_ITEMS = 210;

    typedef struct {
        logic [FUNC_W-1:0] func;
        logic              flag;
        logic [CMD_W-1:0]  command;
        logic [ARG_W-1:0]  argument;
        logic [NOW_W-1:0]  now_ms;
    } evt_item_t;

    typedef struct {
        logic               accepted;
        logic [STATE_W-1:0] state_code;
        logic               aux_on;
        logic               isolated_on;
        logic               low_side_on;
        logic               outputs_safe;
    } status_item_t;

    // interlock state copy and the status items it predicts
    class interlock_scoreboard;
        logic               role;
        logic [HOLD_W-1:0]  arm_hold;
        logic [LINK_W-1:0]  link_loss;
        logic [LEASE_W-1:0] arm_lease;
        logic [PULSE_W-1:0] max_pulse;
        logic [STATE_W-1:0] mode;
        logic               paired;
        logic               held;
        logic               aux;
        logic               iso;
        logic               low;
        logic [NOW_W-1:0]   pulse_dl;
        logic [NOW_W-1:0]   lease_dl;
        logic [NOW_W-1:0]   hb_dl;
        logic [NOW_W-1:0]   press_t;
        logic [1:0]         frames;
        status_item_t       expected_status_q[$];
        int                 mismatches;

        function new();
            role      = ROLE_RST;
            arm_hold  = ARM_HOLD_RST;
            link_loss = LINK_RST;
            arm_lease = LEASE_RST;
            max_pulse = MAX_PULSE_RST;
            mode      = ST_BOOT;
            paired    = 1'b0;
            held      = 1'b0;
            aux       = 1'b0;
            iso       = 1'b0;
            low       = 1'b0;
            pulse_dl  = '0;
            lease_dl  = '0;
            hb_dl     = '0;
            press_t   = '0;
            frames    = '0;
            mismatches = 0;
        endfunction

        function void set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
            case (idx)
                REG_ROLE:      role = value[0];
                REG_ARM_HOLD:  arm_hold = value[HOLD_W-1:0];
                REG_LINK_LOSS: link_loss = value[LINK_W-1:0];
                REG_ARM_LEASE: arm_lease = value[LEASE_W-1:0];
                REG_MAX_PULSE: max_pulse = value[PULSE_W-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_status_q.size();
        endfunction

        // deadline reached when the wrapped difference is non-negative
        function logic reached(input logic [NOW_W-1:0] t_now, input logic [NOW_W-1:0] dl);
            logic [NOW_W-1:0] diff;
            diff = t_now - dl;
            return !diff[NOW_W-1];
        endfunction

        function void drives_off();
            aux      = 1'b0;
            iso      = 1'b0;
            low      = 1'b0;
            pulse_dl = '0;
        endfunction

        function void go_safe(input logic [STATE_W-1:0] nxt_mode);
            drives_off();
            lease_dl = '0;
            hb_dl    = '0;
            mode     = nxt_mode;
        endfunction

        function logic locked();
            return mode == ST_BOOT || mode == ST_UNPAIRED || mode == ST_PAIRING_AUTH ||
                   mode == ST_FAULT || mode == ST_UPDATE;
        endfunction

        function logic armed_like();
            return mode == ST_ARMED || mode == ST_CMD_PENDING;
        endfunction

        // remote command, returns the accept flag
        function logic run_command(input logic [CMD_W-1:0] cmd, input logic [ARG_W-1:0] arg,
                                   input logic [NOW_W-1:0] t_now);
            if (role != ROLE_RECEIVER || !paired || locked())
                return 1'b0;
            if (cmd == CMD_DISARM)
            begin
                go_safe(ST_DISARMED);
                return 1'b1;
            end
            if (cmd == CMD_HEARTBEAT)
            begin
                hb_dl = t_now + NOW_W'(link_loss);
                return 1'b1;
            end
            if (cmd == CMD_ARM_LEASE)
            begin
                lease_dl = t_now + NOW_W'(arm_lease);
                hb_dl    = t_now + NOW_W'(link_loss);
                mode     = ST_ARMED;
                return 1'b1;
            end
            // output commands need a live lease
            if (!armed_like() || reached(t_now, lease_dl))
            begin
                go_safe(ST_DISARMED);
                return 1'b0;
            end
            hb_dl = t_now + NOW_W'(link_loss);
            if (cmd == CMD_SET_AUX)
            begin
                if (arg > 1)
                    return 1'b0;
                drives_off();
                aux  = (arg != 0);
                mode = aux ? ST_CMD_PENDING : ST_ARMED;
                return 1'b1;
            end
            if (cmd == CMD_PULSE_ISO || cmd == CMD_PULSE_LOW)
            begin
                if (arg == 0 || arg > max_pulse)
                    return 1'b0;
                drives_off();
                iso      = (cmd == CMD_PULSE_ISO);
                low      = (cmd == CMD_PULSE_LOW);
                pulse_dl = t_now + NOW_W'(arg);
                mode     = ST_CMD_PENDING;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        // time checks on a tick
        function void run_tick(input logic [NOW_W-1:0] t_now);
            if (role == ROLE_WAND && mode == ST_ARM_PENDING && held &&
                reached(t_now, press_t + NOW_W'(arm_hold)))
                mode = ST_ARMED;
            if (role != ROLE_RECEIVER)
                return;
            if (armed_like() && reached(t_now, lease_dl))
            begin
                go_safe(ST_DISARMED);
                return;
            end
            if (armed_like() && reached(t_now, hb_dl))
            begin
                go_safe(ST_DISARMED);
                return;
            end
            if (mode == ST_CMD_PENDING && (iso || low) && reached(t_now, pulse_dl))
            begin
                drives_off();
                mode = ST_ARMED;
            end
        endfunction

        // apply one accepted event item and queue its status item
        function void note_event(input evt_item_t e);
            status_item_t s;
            logic         acc;
            acc = 1'b0;
            case (e.func)
                FN_TICK: run_tick(e.now_ms);
                FN_BOOT_DONE:
                begin
                    drives_off();
                    paired = e.flag;
                    if (role == ROLE_WAND && held)
                        mode = ST_FAULT;
                    else
                        mode = e.flag ? ST_DISARMED : ST_UNPAIRED;
                end
                FN_SET_PAIRING:
                begin
                    go_safe(e.flag ? ST_DISARMED : ST_UNPAIRED);
                    paired = e.flag;
                end
                FN_ARM_BUTTON:
                begin
                    if (role == ROLE_WAND)
                    begin
                        held = e.flag;
                        if (!locked())
                        begin
                            if (!e.flag)
                            begin
                                go_safe(ST_DISARMED);
                                frames = DISARM_FRAMES;
                            end
                            else if (mode == ST_DISARMED)
                            begin
                                press_t = e.now_ms;
                                mode    = ST_ARM_PENDING;
                            end
                        end
                    end
                end
                FN_LINK_LOST: go_safe(paired ? ST_DISARMED : ST_UNPAIRED);
                FN_FAULT: go_safe(ST_FAULT);
                FN_COMMAND: acc = run_command(e.command, e.argument, e.now_ms);
                default:
                begin
                    if (role == ROLE_WAND && frames != 0)
                    begin
                        frames = frames - 1'b1;
                        acc    = 1'b1;
                    end
                end
            endcase
            s.accepted     = acc;
            s.state_code   = mode;
            s.aux_on       = aux;
            s.isolated_on  = iso;
            s.low_side_on  = low;
            s.outputs_safe = !(aux || iso || low);
            expected_status_q.push_back(s);
        endfunction

        function void check_status(input status_item_t got);
            status_item_t want;
            if (expected_status_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected status item: state %0d", got.state_code);
                return;
            end
            want = expected_status_q.pop_front();
            if (got.accepted !== want.accepted || got.state_code !== want.state_code ||
                got.aux_on !== want.aux_on || got.isolated_on !== want.isolated_on ||
                got.low_side_on !== want.low_side_on || got.outputs_safe !== want.outputs_safe)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("status mismatch: expected acc=%0b st=%0d aux=%0b iso=%0b low=%0b safe=%0b, got acc=%0b st=%0d aux=%0b iso=%0b low=%0b safe=%0b",
                             want.accepted, want.state_code, want.aux_on, want.isolated_on,
                             want.low_side_on, want.outputs_safe, got.accepted, got.state_code,
                             got.aux_on, got.isolated_on, got.low_side_on, got.outputs_safe);
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    alsi_evt_if evt_ch();
    alsi_res_if res_ch();

    interlock_scoreboard sb;
    evt_item_t           pending_evts[$];
    evt_item_t           next_evt;
    evt_item_t           seen_evt;
    status_item_t        seen_status;
    int unsigned         pushed_evts;
    int unsigned         accepted_evts;
    logic                evt_taken;
    int unsigned         send_idle_pct;
    int unsigned         recv_idle_pct;
    int unsigned         cycles;
    logic [NOW_W-1:0]    stamp_ms;
    logic [PULSE_W-1:0]  cfg_maxp;
    logic [LINK_W-1:0]   cfg_link;

    arm_lease_safety_interlock_core DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .evt     (evt_ch),
        .res     (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // event sender, holds an item until it is taken
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!evt_ch.valid || evt_taken)
            begin
                if (pending_evts.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_evt = pending_evts.pop_front();
                    evt_ch.valid    <= 1'b1;
                    evt_ch.func     <= next_evt.func;
                    evt_ch.flag     <= next_evt.flag;
                    evt_ch.command  <= next_evt.command;
                    evt_ch.argument <= next_evt.argument;
                    evt_ch.now_ms   <= next_evt.now_ms;
                end
                else
                    evt_ch.valid <= 1'b0;
            end
            evt_taken = 1'b0;
        end
    end

    // status receiver stalls
    always @(negedge clk)
    begin
        if (rst_n)
            res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // handshake monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (evt_ch.valid && evt_ch.ready)
            begin
                seen_evt.func     = evt_ch.func;
                seen_evt.flag     = evt_ch.flag;
                seen_evt.command  = evt_ch.command;
                seen_evt.argument = evt_ch.argument;
                seen_evt.now_ms   = evt_ch.now_ms;
                sb.note_event(seen_evt);
                accepted_evts++;
                evt_taken = 1'b1;
            end
            if (res_ch.valid && res_ch.ready)
            begin
                seen_status.accepted     = res_ch.accepted;
                seen_status.state_code   = res_ch.state_code;
                seen_status.aux_on       = res_ch.aux_on;
                seen_status.isolated_on  = res_ch.isolated_on;
                seen_status.low_side_on  = res_ch.low_side_on;
                seen_status.outputs_safe = res_ch.outputs_safe;
                sb.check_status(seen_status);
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic void emit(input logic [FUNC_W-1:0] func, input logic flag,
                                 input logic [CMD_W-1:0] cmd, input logic [ARG_W-1:0] arg,
                                 input logic [NOW_W-1:0] t_now);
        evt_item_t it;
        it.func     = func;
        it.flag     = flag;
        it.command  = cmd;
        it.argument = arg;
        it.now_ms   = t_now;
        pending_evts.push_back(it);
        pushed_evts++;
    endfunction

    // event whose other fields do not matter
    function automatic void emit_plain(input logic [FUNC_W-1:0] func);
        emit(func, 1'($urandom_range(1)), CMD_W'($urandom_range(7)),
             ARG_W'($urandom_range(65535)), stamp_ms);
    endfunction

    function automatic void emit_cmd(input logic [CMD_W-1:0] cmd, input logic [ARG_W-1:0] arg);
        emit(FN_COMMAND, 1'($urandom_range(1)), cmd, arg, stamp_ms);
    endfunction

    // move the timestamp, now and then far or anywhere
    function automatic void advance_time(input int unsigned span);
        int unsigned r;
        r = $urandom_range(99);
        if (r == 0)
            stamp_ms = $urandom;
        else if (r < 5)
            stamp_ms = stamp_ms + $urandom_range(0, 32'h00FF_FFFF);
        else
            stamp_ms = stamp_ms + $urandom_range(0, span);
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_reg(idx, value);
    endtask

    // wait until every event is taken and every status item has come
    task automatic wait_drained();
        while (accepted_evts != pushed_evts || sb.pending() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    // one register setting and a stretch of random sessions under it
    task automatic run_phase(input logic role, input logic [HOLD_W-1:0] hold,
                             input logic [LINK_W-1:0] link, input logic [LEASE_W-1:0] lease,
                             input logic [PULSE_W-1:0] maxp, input int unsigned nitems);
        int unsigned first;
        int unsigned r;
        int unsigned span;
        logic [ARG_W-1:0] plen;
        wait_drained();
        write_reg(REG_ROLE, CFG_DATA_W'(role));
        write_reg(REG_ARM_HOLD, CFG_DATA_W'(hold));
        write_reg(REG_LINK_LOSS, CFG_DATA_W'(link));
        write_reg(REG_ARM_LEASE, CFG_DATA_W'(lease));
        write_reg(REG_MAX_PULSE, CFG_DATA_W'(maxp));
        cfg_maxp = maxp;
        cfg_link = link;
        stamp_ms = $urandom;
        first    = pushed_evts;
        emit(FN_SET_PAIRING, 1'b1, CMD_W'($urandom_range(7)), ARG_W'($urandom_range(65535)),
             stamp_ms);
        while (pushed_evts - first < nitems)
        begin
            if ($urandom_range(99) < 12)
            begin
                // noise: any event, any field, any time
                emit(FUNC_W'($urandom_range(7)), 1'($urandom_range(1)),
                     CMD_W'($urandom_range(7)), ARG_W'($urandom_range(65535)),
                     ($urandom_range(3) == 0) ? NOW_W'($urandom) : stamp_ms);
            end
            else
            begin
                // occasional re-boot or re-pair, mostly paired
                r = $urandom_range(7);
                if (r == 0)
                    emit(FN_BOOT_DONE, 1'($urandom_range(5) != 0), CMD_W'($urandom_range(7)),
                         ARG_W'($urandom_range(65535)), stamp_ms);
                else if (r == 1)
                    emit(FN_SET_PAIRING, 1'($urandom_range(5) != 0), CMD_W'($urandom_range(7)),
                         ARG_W'($urandom_range(65535)), stamp_ms);
                if (role == ROLE_WAND)
                begin
                    // press, hold through ticks, release, drain disarm frames
                    span = hold / 2 + 2;
                    emit(FN_ARM_BUTTON, 1'b1, CMD_W'($urandom_range(7)),
                         ARG_W'($urandom_range(65535)), stamp_ms);
                    repeat ($urandom_range(1, 4))
                    begin
                        advance_time(span);
                        emit_plain(FN_TICK);
                    end
                    if ($urandom_range(5) == 0)
                        emit_plain(FN_COMMAND);
                    advance_time(span);
                    emit(FN_ARM_BUTTON, 1'b0, CMD_W'($urandom_range(7)),
                         ARG_W'($urandom_range(65535)), stamp_ms);
                    repeat ($urandom_range(0, 4))
                        emit_plain(FN_TAKE_DISARM);
                    if ($urandom_range(9) == 0)
                        emit_plain($urandom_range(1) ? FN_FAULT : FN_LINK_LOST);
                end
                else
                begin
                    // lease, then a run of commands and ticks
                    emit_cmd(CMD_ARM_LEASE, ARG_W'($urandom_range(65535)));
                    repeat ($urandom_range(2, 8))
                    begin
                        span = $urandom_range(1) ? int'(cfg_maxp) : int'(cfg_link);
                        if (span > 5000)
                            span = 5000;
                        advance_time(span + 2);
                        r = $urandom_range(99);
                        if (r < 22)
                            emit_plain(FN_TICK);
                        else if (r < 36)
                            emit_cmd(CMD_HEARTBEAT, ARG_W'($urandom_range(65535)));
                        else if (r < 50)
                            emit_cmd(CMD_SET_AUX, ($urandom_range(4) == 0) ?
                                     ARG_W'($urandom_range(2, 65535)) :
                                     ARG_W'($urandom_range(1)));
                        else if (r < 76)
                        begin
                            r = $urandom_range(9);
                            if (r == 0)
                                plen = '0;
                            else if (r == 1 && cfg_maxp != '1)
                                plen = ARG_W'($urandom_range(32'(cfg_maxp) + 1, 65535));
                            else
                                plen = ARG_W'($urandom_range(1, 32'(cfg_maxp)));
                            emit_cmd($urandom_range(1) ? CMD_PULSE_ISO : CMD_PULSE_LOW, plen);
                        end
                        else if (r < 83)
                            emit_cmd($urandom_range(1) ? CMD_FEEDBACK : CMD_RESERVED,
                                     ARG_W'($urandom_range(65535)));
                        else if (r < 88)
                            emit_cmd(CMD_DISARM, ARG_W'($urandom_range(65535)));
                        else if (r < 92)
                            emit_cmd(CMD_ARM_LEASE, ARG_W'($urandom_range(65535)));
                        else
                            emit_plain($urandom_range(1) ? FN_ARM_BUTTON : FN_TAKE_DISARM);
                    end
                end
            end
        end
    endtask

    // main sequence
    initial
    begin
        sb = new();
        rst_n           = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        evt_ch.valid    = 1'b0;
        evt_ch.func     = FN_TICK;
        evt_ch.flag     = 1'b0;
        evt_ch.command  = CMD_DISARM;
        evt_ch.argument = '0;
        evt_ch.now_ms   = '0;
        res_ch.ready    = 1'b0;
        evt_taken       = 1'b0;
        pushed_evts     = 0;
        accepted_evts   = 0;
        cycles          = 0;
        stamp_ms        = '0;
        cfg_maxp        = MAX_PULSE_RST;
        cfg_link        = LINK_RST;
        send_idle_pct   = 29;
        recv_idle_pct   = 60;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // wand role, reset register values
        emit(FN_COMMAND, 1'b0, CMD_HEARTBEAT, 16'd0, 32'd0);
        emit(FN_BOOT_DONE, 1'b1, CMD_DISARM, 16'hFFFF, 32'd0);
        emit(FN_ARM_BUTTON, 1'b1, CMD_RESERVED, 16'd0, 32'd100);
        emit(FN_TICK, 1'b0, CMD_DISARM, 16'd0, 32'd599);
        emit(FN_TICK, 1'b1, CMD_RESERVED, 16'hFFFF, 32'd600);
        emit(FN_COMMAND, 1'b1, CMD_ARM_LEASE, 16'd0, 32'd650);
        emit(FN_ARM_BUTTON, 1'b0, CMD_DISARM, 16'd0, 32'd700);
        repeat (4) emit(FN_TAKE_DISARM, 1'b0, CMD_DISARM, 16'd0, 32'd710);
        emit(FN_ARM_BUTTON, 1'b1, CMD_DISARM, 16'd0, 32'd800);
        emit(FN_BOOT_DONE, 1'b0, CMD_DISARM, 16'd0, 32'd810);
        emit(FN_SET_PAIRING, 1'b0, CMD_DISARM, 16'd0, 32'd820);
        emit(FN_LINK_LOST, 1'b0, CMD_DISARM, 16'd0, 32'd830);
        emit(FN_FAULT, 1'b1, CMD_RESERVED, 16'hFFFF, 32'hFFFF_FFFF);
        wait_drained();

        // receiver role, lease granted just before the timestamp wraps
        write_reg(REG_ROLE, CFG_DATA_W'(ROLE_RECEIVER));
        emit(FN_SET_PAIRING, 1'b1, CMD_DISARM, 16'd0, 32'hFFFF_FDF0);
        emit(FN_COMMAND, 1'b1, CMD_SET_AUX, 16'd1, 32'hFFFF_FDF8);
        emit(FN_COMMAND, 1'b0, CMD_ARM_LEASE, 16'd0, 32'hFFFF_FE00);
        emit(FN_COMMAND, 1'b0, CMD_SET_AUX, 16'd2, 32'hFFFF_FE02);
        emit(FN_COMMAND, 1'b0, CMD_SET_AUX, 16'd1, 32'hFFFF_FE04);
        emit(FN_COMMAND, 1'b0, CMD_PULSE_ISO, 16'd0, 32'hFFFF_FE08);
        // pulse deadline lands exactly on zero
        emit(FN_COMMAND, 1'b0, CMD_PULSE_ISO, 16'd500, 32'hFFFF_FE0C);
        emit(FN_TICK, 1'b0, CMD_DISARM, 16'd0, 32'd0);
        emit(FN_COMMAND, 1'b1, CMD_PULSE_LOW, 16'hFFFF, 32'd1);
        emit(FN_COMMAND, 1'b1, CMD_FEEDBACK, 16'd0, 32'd2);
        emit(FN_COMMAND, 1'b1, CMD_RESERVED, 16'd0, 32'd3);
        emit(FN_ARM_BUTTON, 1'b1, CMD_DISARM, 16'd0, 32'd3);
        emit(FN_TAKE_DISARM, 1'b0, CMD_DISARM, 16'd0, 32'd3);
        emit(FN_TICK, 1'b0, CMD_DISARM, 16'd0, 32'd1004);
        emit(FN_COMMAND, 1'b1, CMD_DISARM, 16'd0, 32'd1010);

        // receiver stalls more than sender idles
        run_phase(ROLE_WAND, 16'd0, 20'hFFFFF, 20'd0, 16'd1, PHASE_ITEMS);
        run_phase(ROLE_RECEIVER, 16'hFFFF, 20'hFFFFF, 20'hFFFFF, 16'hFFFF, PHASE_ITEMS);

        // sender idles more than receiver stalls
        wait_drained();
        send_idle_pct = 60;
        recv_idle_pct = 29;
        run_phase(ROLE_WAND, 16'hFFFF, LINK_W'($urandom_range(20'hFFFFF)),
                  LEASE_W'($urandom_range(20'hFFFFF)), PULSE_W'($urandom_range(1, 16'hFFFF)),
                  PHASE_ITEMS);
        run_phase(ROLE_RECEIVER, HOLD_W'($urandom_range(16'hFFFF)), 20'd0,
                  LEASE_W'($urandom_range(1000, 20000)), 16'd1, PHASE_ITEMS);

        // no idling at all
        wait_drained();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_phase(ROLE_WAND, HOLD_W'($urandom_range(1, 2000)), LINK_W'($urandom_range(20'hFFFFF)),
                  LEASE_W'($urandom_range(20'hFFFFF)), PULSE_W'($urandom_range(1, 16'hFFFF)),
                  PHASE_ITEMS);
        run_phase(ROLE_RECEIVER, HOLD_W'($urandom_range(16'hFFFF)),
                  LINK_W'($urandom_range(300, 3000)), LEASE_W'($urandom_range(2000, 20000)),
                  PULSE_W'($urandom_range(1, 2000)), PHASE_ITEMS);

        wait_drained();
        if (sb.mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

FILE: arm_lease_safety_interlock_core.f
sv/alsi_pkg.sv
sv/alsi_evt_if.sv
sv/alsi_res_if.sv
sv/arm_lease_safety_interlock_core.sv
dv/arm_lease_safety_interlock_core_tb.sv
